/* src/aws_pkg.sv */
package aws_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned LenW    = 24;
  localparam int unsigned SumW    = 54;
  localparam int unsigned CountW  = 24;
  localparam int unsigned RmsW    = 24;

  // Divide / root datapath widths
  localparam int unsigned FracW   = 16;               // fraction bits of the mean
  localparam int unsigned DivW    = SumW + FracW;     // dividend bits, one per divide step
  localparam int unsigned MeanW   = 64;               // mean is kept modulo 2^64
  localparam int unsigned RootW   = MeanW / 2;        // one root bit per step
  localparam int unsigned RemW    = RootW + 2;        // partial remainder
  localparam int unsigned StepW   = $clog2(DivW);

  localparam logic [StepW-1:0] DivLast  = StepW'(DivW - 1);
  localparam logic [StepW-1:0] RootLast = StepW'(RootW - 1);

  // Sample limits and reset values
  localparam logic signed [SampleW-1:0] Int16Min = 16'sh8000;
  localparam logic signed [SampleW-1:0] Int16Max = 16'sh7FFF;
  localparam logic [LenW-1:0]           LenReset = 24'd48000;

  typedef enum logic [2:0] {
    StIdle,
    StAcc,
    StDiv,
    StRoot,
    StDone
  } state_e;

endpackage

/* src/audio_window_stats_unit.sv */
// A sample that does not close a window is captured in StIdle and accumulated in StAcc.
// A window-closing sample then passes StDiv, StRoot and StDone up to the result register:
// 70 restoring-divide steps and 32 square-root steps, all on one shared 34-bit subtractor.
// A new sample is taken only once the last one is accumulated (ready only in StIdle); a
// new window may start while the previous result still waits in the output register.
// Reset (rst_ni low, async): window length 48000, accumulators cleared, no result pending.
module audio_window_stats_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: window length
  input  logic                                 cfg_we_i,
  input  logic [aws_pkg::LenW-1:0]             cfg_wdata_i,
  // sample request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [aws_pkg::SampleW-1:0]   sample_i,
  // result request channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [aws_pkg::RmsW-1:0]             rms_value_o,
  output logic signed [aws_pkg::SampleW-1:0]   peak_high_o,
  output logic signed [aws_pkg::SampleW-1:0]   peak_low_o,
  output logic [aws_pkg::CountW-1:0]           crossing_count_o
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  aws_pkg::state_e state_q, state_d;

  logic [aws_pkg::LenW-1:0]            len_q;
  logic signed [aws_pkg::SampleW-1:0]  sample_q;

  // window accumulators
  logic [aws_pkg::SumW-1:0]            sum_q, sum_d;
  logic [aws_pkg::CountW-1:0]          seen_q, seen_d;
  logic signed [aws_pkg::SampleW-1:0]  max_q, max_d;
  logic signed [aws_pkg::SampleW-1:0]  min_q, min_d;
  logic [aws_pkg::CountW-1:0]          cross_q, cross_d;
  logic                                prev_neg_q, prev_neg_d;

  // shared divide / root datapath
  logic [aws_pkg::DivW-1:0]            work_q, work_d;   // dividend in, quotient out
  logic [aws_pkg::RemW-1:0]            rem_q, rem_d;
  logic [aws_pkg::RootW-1:0]           root_q, root_d;
  logic [aws_pkg::StepW-1:0]           step_q, step_d;

  // result register
  logic                                out_valid_q, out_valid_d;
  logic [aws_pkg::RmsW-1:0]            rms_q, rms_d;
  logic signed [aws_pkg::SampleW-1:0]  peak_high_q, peak_high_d;
  logic signed [aws_pkg::SampleW-1:0]  peak_low_q, peak_low_d;
  logic [aws_pkg::CountW-1:0]          count_q, count_d;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                                in_fire;
  logic                                load_result;
  logic [aws_pkg::LenW-1:0]            len_eff;     // zero length acts as one
  logic                                win_end;
  logic                                neg;
  logic [aws_pkg::SampleW-1:0]         mag;
  logic [2*aws_pkg::SampleW-1:0]       square;
  logic [aws_pkg::SumW-1:0]            sum_new;

  // shared subtractor
  logic [aws_pkg::RemW-1:0]            sub_a, sub_b;
  logic [aws_pkg::RemW:0]              sub_diff;
  logic                                sub_borrow;
  logic [aws_pkg::LenW:0]              div_rem_sh;  // remainder shifted, next dividend bit in
  logic [aws_pkg::RemW-1:0]            root_rem_sh; // remainder shifted, next two bits in

  assign in_ready_o  = (state_q == aws_pkg::StIdle);
  assign in_fire     = in_valid_i & in_ready_o;
  assign load_result = (state_q == aws_pkg::StDone) & (~out_valid_q | out_ready_i);

  assign len_eff = (len_q == '0) ? aws_pkg::LenW'(1) : len_q;
  // window closes once the count (plus this sample) reaches the length; also
  // covers a length lowered below the current count
  assign win_end = ({1'b0, seen_q} + (aws_pkg::LenW+1)'(1)) >= {1'b0, len_eff};

  assign neg     = sample_q[aws_pkg::SampleW-1];
  assign mag     = neg ? (-sample_q) : sample_q;   // -32768 maps to 0x8000
  assign square  = mag * mag;
  assign sum_new = sum_q + aws_pkg::SumW'(square);

  assign div_rem_sh  = {rem_q[aws_pkg::LenW-1:0], work_q[aws_pkg::DivW-1]};
  assign root_rem_sh = {rem_q[aws_pkg::RemW-3:0], work_q[aws_pkg::MeanW-1 -: 2]};

  // operand select: divide compares against the length, root against the trial value
  always_comb begin
    if (state_q == aws_pkg::StDiv) begin
      sub_a = aws_pkg::RemW'(div_rem_sh);
      sub_b = aws_pkg::RemW'(len_eff);
    end else begin
      sub_a = root_rem_sh;
      sub_b = {root_q, 2'b01};
    end
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[aws_pkg::RemW];

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      aws_pkg::StIdle: begin
        if (in_fire) state_d = aws_pkg::StAcc;
      end
      aws_pkg::StAcc: begin
        state_d = win_end ? aws_pkg::StDiv : aws_pkg::StIdle;
      end
      aws_pkg::StDiv: begin
        if (step_q == aws_pkg::DivLast) state_d = aws_pkg::StRoot;
      end
      aws_pkg::StRoot: begin
        if (step_q == aws_pkg::RootLast) state_d = aws_pkg::StDone;
      end
      aws_pkg::StDone: begin
        if (load_result) state_d = aws_pkg::StIdle;
      end
      default: state_d = aws_pkg::StIdle;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath controls
  // ---------------------------------------------------------------------------
  always_comb begin
    sum_d       = sum_q;
    seen_d      = seen_q;
    max_d       = max_q;
    min_d       = min_q;
    cross_d     = cross_q;
    prev_neg_d  = prev_neg_q;
    work_d      = work_q;
    rem_d       = rem_q;
    root_d      = root_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    rms_d       = rms_q;
    peak_high_d = peak_high_q;
    peak_low_d  = peak_low_q;
    count_d     = count_q;

    case (state_q)
      aws_pkg::StAcc: begin
        sum_d      = sum_new;
        prev_neg_d = neg;
        if (sample_q > max_q) max_d = sample_q;
        if (sample_q < min_q) min_d = sample_q;
        // first sample of a window never counts as a crossing
        if ((seen_q != '0) && (neg != prev_neg_q)) cross_d = cross_q + aws_pkg::CountW'(1);
        if (win_end) begin
          work_d = {sum_new, aws_pkg::FracW'(0)};
          rem_d  = '0;
          step_d = '0;
        end else begin
          seen_d = seen_q + aws_pkg::CountW'(1);
        end
      end

      // restoring divide, one quotient bit per cycle
      aws_pkg::StDiv: begin
        rem_d  = sub_borrow ? aws_pkg::RemW'(div_rem_sh) : sub_diff[aws_pkg::RemW-1:0];
        work_d = {work_q[aws_pkg::DivW-2:0], ~sub_borrow};
        step_d = step_q + aws_pkg::StepW'(1);
        if (step_q == aws_pkg::DivLast) begin
          rem_d  = '0;
          root_d = '0;
          step_d = '0;
        end
      end

      // digit-by-digit square root of the low 64 quotient bits, one root bit per cycle
      aws_pkg::StRoot: begin
        rem_d  = sub_borrow ? root_rem_sh : sub_diff[aws_pkg::RemW-1:0];
        root_d = {root_q[aws_pkg::RootW-2:0], ~sub_borrow};
        work_d = {work_q[aws_pkg::DivW-3:0], 2'b00};
        step_d = step_q + aws_pkg::StepW'(1);
      end

      aws_pkg::StDone: begin
        if (load_result) begin
          out_valid_d = 1'b1;
          rms_d       = root_q[aws_pkg::RmsW-1:0];
          peak_high_d = max_q;
          peak_low_d  = min_q;
          count_d     = cross_q;
          // open the next window
          sum_d       = '0;
          seen_d      = '0;
          max_d       = aws_pkg::Int16Min;
          min_d       = aws_pkg::Int16Max;
          cross_d     = '0;
          prev_neg_d  = 1'b0;
        end
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // State and accumulators
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aws_pkg::StIdle;
      len_q       <= aws_pkg::LenReset;
      sum_q       <= '0;
      seen_q      <= '0;
      max_q       <= aws_pkg::Int16Min;
      min_q       <= aws_pkg::Int16Max;
      cross_q     <= '0;
      prev_neg_q  <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) len_q <= cfg_wdata_i;   // accumulators are kept on a length change
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      max_q       <= max_d;
      min_q       <= min_d;
      cross_q     <= cross_d;
      prev_neg_q  <= prev_neg_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) sample_q <= sample_i;
    work_q      <= work_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    rms_q       <= rms_d;
    peak_high_q <= peak_high_d;
    peak_low_q  <= peak_low_d;
    count_q     <= count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign rms_value_o      = rms_q;
  assign peak_high_o      = peak_high_q;
  assign peak_low_o       = peak_low_q;
  assign crossing_count_o = count_q;

endmodule
